[design/dgbs_pkg.sv]
// shared types, constants and helpers for the distance grid bilinear sampler
// no dependencies; imported by every module of the block
`default_nettype none

package dgbs_pkg;

	localparam int MAX_GRID_DIM = 256;
	localparam int VALUE_BITS   = 16;
	localparam int ADDR_W       = 16;
	localparam int DIM_W        = 9;
	localparam int STORE_DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM;

	// item kinds on tuser of the input channel
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_INV_RESOLUTION = 2'd2;
	localparam logic [1:0] REG_OUTSIDE_VALUE  = 2'd3;

	localparam logic [DIM_W-1:0] RST_GRID_WIDTH     = 9'd220;
	localparam logic [DIM_W-1:0] RST_GRID_HEIGHT    = 9'd220;
	localparam logic [15:0]      RST_INV_RESOLUTION = 16'd5120;
	localparam logic [15:0]      RST_OUTSIDE_VALUE  = 16'd2560;

	// operand and product types of the shared multiplier
	typedef logic signed [35:0] mul_a_t;
	typedef logic signed [17:0] mul_b_t;
	typedef logic signed [53:0] mul_p_t;

	typedef struct packed {
		logic [DIM_W-1:0] grid_width;
		logic [DIM_W-1:0] grid_height;
		logic [15:0]      inv_resolution;
		logic [15:0]      outside_value;
	} cfg_t;

	// laid out like tdata, cell_index in the lowest bits
	typedef struct packed {
		logic [15:0] query_y;
		logic [15:0] query_x;
		logic [15:0] cell_value;
		logic [15:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [15:0] grad_y;
		logic [15:0] grad_x;
		logic [15:0] distance;
	} res_data_t;

	typedef struct packed {
		res_data_t data;
		logic      in_grid;
	} res_t;

	function automatic logic [15:0] sat16(input logic signed [47:0] v);
		logic [15:0] r;
		if (v > 48'sd32767) begin
			r = 16'h7fff;
		end else if (v < -48'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/dgbs_grid_mem.sv]
// single-port grid store, one cell per entry, registered read data
// uses dgbs_pkg for the address and value widths and the store depth
`default_nettype none

module dgbs_grid_mem (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [dgbs_pkg::ADDR_W-1:0]   addr,
	input  wire logic [dgbs_pkg::VALUE_BITS-1:0] wdata,
	output logic      [dgbs_pkg::VALUE_BITS-1:0] rdata
);
	import dgbs_pkg::*;

	logic [VALUE_BITS-1:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

[design/dgbs_mult.sv]
// shared signed multiplier with a registered product
// uses the operand types of dgbs_pkg
`default_nettype none

module dgbs_mult (
	input  wire logic            clk,
	input  wire dgbs_pkg::mul_a_t op_a,
	input  wire dgbs_pkg::mul_b_t op_b,
	output dgbs_pkg::mul_p_t      prod_q
);
	import dgbs_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= mul_p_t'(op_a) * mul_p_t'(op_b);
	end

endmodule

`default_nettype wire

[design/dgbs_core.sv]
// sequencer and datapath: grid writes, four-cell fetch and bilinear blend
// uses dgbs_pkg, dgbs_grid_mem and dgbs_mult
`default_nettype none

module dgbs_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dgbs_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           in_kind,
	input  wire dgbs_pkg::item_t in_item,
	output logic                res_valid,
	input  wire logic           res_ready,
	output dgbs_pkg::res_t      res
);
	import dgbs_pkg::*;

	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_MX   = 20'h00002,
		ST_MY   = 20'h00004,
		ST_CHK  = 20'h00008,
		ST_BASE = 20'h00010,
		ST_R0   = 20'h00020,
		ST_R1   = 20'h00040,
		ST_R2   = 20'h00080,
		ST_R3   = 20'h00100,
		ST_R4   = 20'h00200,
		ST_DIF  = 20'h00400,
		ST_MA   = 20'h00800,
		ST_MB   = 20'h01000,
		ST_MC   = 20'h02000,
		ST_MD   = 20'h04000,
		ST_ME   = 20'h08000,
		ST_MF   = 20'h10000,
		ST_MG   = 20'h20000,
		ST_MH   = 20'h40000,
		ST_FIN  = 20'h80000
	} state_t;

	state_t state_q, state_nxt;

	logic signed [15:0] x_q, y_q;
	logic signed [17:0] ix_q, iy_q;
	logic [15:0]        tx_q, ty_q;
	logic [ADDR_W-1:0]  base_q;
	logic signed [15:0] v00_q, v10_q, v01_q, v11_q;
	logic signed [16:0] a_q, b_q;
	logic signed [17:0] c_q;
	logic signed [34:0] acc_q, txc_q;
	logic signed [20:0] sx_q, sy_q;
	res_t               res_q;

	logic [DIM_W-1:0]   w_eff, h_eff;
	mul_a_t             op_a;
	mul_b_t             op_b;
	mul_p_t             prod_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_addr;
	logic [15:0]        mem_rdata;
	logic signed [33:0] gq;
	logic               outside;
	logic signed [36:0] slope_full;
	logic signed [55:0] v_full;
	logic signed [53:0] g_full;
	logic               accept;

	assign w_eff = (cfg.grid_width > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : cfg.grid_width;
	assign h_eff = (cfg.grid_height > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM)
		: cfg.grid_height;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_FIN);
	assign res       = res_q;

	// grid coordinate in Q18.16, shifted back by half a cell
	assign gq = $signed(prod_q[33:0]) - 34'sd32768;

	// square must have both corners inside on each axis
	assign outside = ix_q[17] || iy_q[17]
		|| (({1'b0, ix_q[16:0]} + 18'd1) >= {9'd0, w_eff})
		|| (({1'b0, iy_q[16:0]} + 18'd1) >= {9'd0, h_eff});

	// 2^16 * diff + t * c, rounded to Q13.8
	assign slope_full = (state_q == ST_MD)
		? (37'(b_q) <<< 16) + 37'($signed(prod_q[34:0])) + 37'sd32768
		: (37'(a_q) <<< 16) + 37'($signed(prod_q[34:0])) + 37'sd32768;

	assign v_full = (56'(v00_q) <<< 32) + (56'(acc_q) <<< 16) + 56'(prod_q)
		+ 56'sd2147483648;

	assign g_full = prod_q + 54'sd128;

	dgbs_mult u_mult (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	dgbs_grid_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (in_item.cell_value),
		.rdata (mem_rdata)
	);

	assign mem_we = accept && (in_kind == KIND_WRITE);

	always_comb begin
		case (state_q)
			ST_R0:   mem_addr = prod_q[15:0] + ix_q[15:0];
			ST_R1:   mem_addr = base_q + 16'd1;
			ST_R2:   mem_addr = base_q + {7'd0, w_eff};
			ST_R3:   mem_addr = base_q + {7'd0, w_eff} + 16'd1;
			default: mem_addr = in_item.cell_index;
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_MX: begin
				op_a = mul_a_t'(x_q);
				op_b = mul_b_t'({2'b00, cfg.inv_resolution});
			end
			ST_MY: begin
				op_a = mul_a_t'(y_q);
				op_b = mul_b_t'({2'b00, cfg.inv_resolution});
			end
			ST_BASE: begin
				op_a = mul_a_t'(iy_q);
				op_b = mul_b_t'({9'd0, w_eff});
			end
			ST_MA: begin
				op_a = mul_a_t'(a_q);
				op_b = mul_b_t'({2'b00, tx_q});
			end
			ST_MB: begin
				op_a = mul_a_t'(b_q);
				op_b = mul_b_t'({2'b00, ty_q});
			end
			ST_MC: begin
				op_a = mul_a_t'(c_q);
				op_b = mul_b_t'({2'b00, tx_q});
			end
			ST_MD: begin
				op_a = mul_a_t'(c_q);
				op_b = mul_b_t'({2'b00, ty_q});
			end
			ST_ME: begin
				op_a = mul_a_t'(txc_q);
				op_b = mul_b_t'({2'b00, ty_q});
			end
			ST_MF: begin
				op_a = mul_a_t'(sx_q);
				op_b = mul_b_t'({2'b00, cfg.inv_resolution});
			end
			ST_MG: begin
				op_a = mul_a_t'(sy_q);
				op_b = mul_b_t'({2'b00, cfg.inv_resolution});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (accept && (in_kind == KIND_QUERY)) state_nxt = ST_MX;
			ST_MX:   state_nxt = ST_MY;
			ST_MY:   state_nxt = ST_CHK;
			ST_CHK:  state_nxt = ST_BASE;
			ST_BASE: state_nxt = outside ? ST_FIN : ST_R0;
			ST_R0:   state_nxt = ST_R1;
			ST_R1:   state_nxt = ST_R2;
			ST_R2:   state_nxt = ST_R3;
			ST_R3:   state_nxt = ST_R4;
			ST_R4:   state_nxt = ST_DIF;
			ST_DIF:  state_nxt = ST_MA;
			ST_MA:   state_nxt = ST_MB;
			ST_MB:   state_nxt = ST_MC;
			ST_MC:   state_nxt = ST_MD;
			ST_MD:   state_nxt = ST_ME;
			ST_ME:   state_nxt = ST_MF;
			ST_MF:   state_nxt = ST_MG;
			ST_MG:   state_nxt = ST_MH;
			ST_MH:   state_nxt = ST_FIN;
			ST_FIN:  if (res_ready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= in_item.query_x;
				y_q <= in_item.query_y;
			end
			ST_MY: begin
				ix_q <= gq[33:16];
				tx_q <= gq[15:0];
			end
			ST_CHK: begin
				iy_q <= gq[33:16];
				ty_q <= gq[15:0];
			end
			ST_BASE: begin
				res_q.data.distance <= cfg.outside_value;
				res_q.data.grad_x   <= '0;
				res_q.data.grad_y   <= '0;
				res_q.in_grid       <= 1'b0;
			end
			ST_R0: base_q <= mem_addr;
			ST_R1: v00_q  <= mem_rdata;
			ST_R2: v10_q  <= mem_rdata;
			ST_R3: v01_q  <= mem_rdata;
			ST_R4: v11_q  <= mem_rdata;
			ST_DIF: begin
				a_q <= 17'(v10_q) - 17'(v00_q);
				b_q <= 17'(v01_q) - 17'(v00_q);
				c_q <= 18'(v11_q) - 18'(v10_q) - 18'(v01_q) + 18'(v00_q);
			end
			ST_MB: acc_q <= $signed(prod_q[34:0]);
			ST_MC: acc_q <= acc_q + $signed(prod_q[34:0]);
			ST_MD: begin
				txc_q <= $signed(prod_q[34:0]);
				sy_q  <= slope_full[36:16];
			end
			ST_ME: sx_q <= slope_full[36:16];
			ST_MF: begin
				res_q.data.distance <= sat16(48'($signed(v_full[55:32])));
				res_q.in_grid       <= 1'b1;
			end
			ST_MG: res_q.data.grad_x <= sat16(48'($signed(g_full[53:8])));
			ST_MH: res_q.data.grad_y <= sat16(48'($signed(g_full[53:8])));
			default: begin
			end
		endcase
	end

	// a query keeps the input closed while it is worked on
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_kind == KIND_QUERY)) |=> !in_ready)
		else $error("input open right after a query");

	// a write finishes in the cycle it is taken
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_kind == KIND_WRITE)) |=> in_ready)
		else $error("write item left the sequencer busy");

	a_outside_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.in_grid) |-> (res.data.grad_x == '0 && res.data.grad_y == '0))
		else $error("outside result with nonzero slope");

	a_inside_needs_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.in_grid) |-> (w_eff >= 9'd2 && h_eff >= 9'd2))
		else $error("inside result on a grid below two cells");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !mem_we)
		else $error("grid written during a query");

endmodule

`default_nettype wire

[design/distance_grid_bilinear_sampler.sv]
// Distance grid bilinear sampler.
// Input stream s_axis: tuser is the item kind (0 writes one cell, 1 queries a point).
// A write stores cell_value at cell_index and gives no result; the sequencer stays idle.
// A query maps (query_x, query_y) in meters to grid coordinates with inv_resolution,
// shifted back by half a cell, fetches the four cells around it and returns the
// bilinear distance and the x/y slopes per meter on m_axis, tuser = inside flag.
// If the square leaves the grid, outside_value comes back with zero slopes.
// A query whose square leaves the grid skips the cell reads and the blend.
// Otherwise one shared 36x18 multiplier is used ten times and the single-port grid
// memory is read four times, one cell per cycle; the input stays closed meanwhile,
// so no new item is taken until the query has finished.
// The output register holds one result; when m_axis stalls, a finished query
// waits in the sequencer and no new item is taken until it moves on.
// Configuration through cfg_we/cfg_index/cfg_data, only while the block is idle.
// Reset (arst_n low) returns the sequencer to idle, empties the output register
// and loads the default registers; grid contents are undefined until written.
`default_nettype none

module distance_grid_bilinear_sampler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // cell_index, cell_value, query_x, query_y
	input  wire logic        s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // distance, grad_x, grad_y
	output logic             m_axis_tuser   // inside_res
);
	import dgbs_pkg::*;

	cfg_t      cfg_q;
	res_t      res;
	logic      res_valid;
	logic      res_ready;
	logic      out_valid_q;
	res_data_t out_data_q;
	logic      out_inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width     <= RST_GRID_WIDTH;
			cfg_q.grid_height    <= RST_GRID_HEIGHT;
			cfg_q.inv_resolution <= RST_INV_RESOLUTION;
			cfg_q.outside_value  <= RST_OUTSIDE_VALUE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:     cfg_q.grid_width     <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT:    cfg_q.grid_height    <= cfg_data[DIM_W-1:0];
				REG_INV_RESOLUTION: cfg_q.inv_resolution <= cfg_data;
				REG_OUTSIDE_VALUE:  cfg_q.outside_value  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dgbs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_item   (item_t'(s_axis_tdata)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q   <= res.data;
			out_inside_q <= res.in_grid;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_inside_q;

endmodule

`default_nettype wire
